[rtl/bfs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfs_pkg
// Shared types, sizes and command codes of the breadth-first traversal unit.
// ----------------------------------------------------------------------------
package bfs_pkg;

  // graph sizes
  localparam int MAX_VERTICES = 64;
  localparam int MAX_EDGES    = 256;

  // field and index widths
  localparam int VTX_W  = 6;
  localparam int VIDX_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int QCNT_W = $clog2(MAX_VERTICES + 1);
  localparam int EIDX_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECNT_W = $clog2(MAX_EDGES + 1);
  localparam int EDGE_W = 2 * VTX_W;

  // limits in signal widths
  localparam logic [VTX_W:0]    VTX_LIMIT = (VTX_W + 1)'(MAX_VERTICES);
  localparam logic [ECNT_W-1:0] EDGE_FULL = ECNT_W'(MAX_EDGES);

  // command codes
  typedef enum logic [1:0] {
    CMD_ADD      = 2'd0,
    CMD_TRAVERSE = 2'd1,
    CMD_CLEAR    = 2'd2
  } cmd_e;

  // input transaction
  typedef struct packed {
    cmd_e             cmd;
    logic [VTX_W-1:0] vertex_a;
    logic [VTX_W-1:0] vertex_b;
  } in_item_t;

  // output transaction
  typedef struct packed {
    logic [VTX_W-1:0] vertex;
    logic             last;
    logic             edges_dropped;
  } out_item_t;

  // traversal request from the command side to the engine
  typedef struct packed {
    logic             go;
    logic [VTX_W-1:0] vertex;
  } walk_req_t;

  // visited vertex handed from the engine to the output register
  typedef struct packed {
    logic             valid;
    logic [VTX_W-1:0] vertex;
    logic             last;
  } emit_t;

endpackage

[rtl/bfs_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfs_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/bfs_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfs_engine
// Traversal sequencer: vertex queue RAM, visited marks, edge store scan.
// ----------------------------------------------------------------------------
module bfs_engine import bfs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  walk_req_t         req_i,
  input  logic [ECNT_W-1:0] edge_count_i,
  output logic [EIDX_W-1:0] edge_raddr_o,
  input  logic [EDGE_W-1:0] edge_rdata_i,
  output emit_t             emit_o,
  input  logic              emit_ready_i,
  output logic              busy_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DEQ  = 3'd1;
  localparam logic [2:0] ST_LOAD = 3'd2;
  localparam logic [2:0] ST_SCAN = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;
  localparam logic [2:0] ST_CLR  = 3'd5;

  localparam logic [VIDX_W-1:0] CLR_LAST = VIDX_W'(MAX_VERTICES - 1);

  logic [2:0]              state_q, state_d;
  logic [QCNT_W-1:0]       head_q, head_d;
  logic [QCNT_W-1:0]       tail_q, tail_d;
  logic [ECNT_W-1:0]       iss_q, iss_d;
  logic                    pv_q, pv_d;
  logic [VTX_W-1:0]        u_q, u_d;
  logic [VIDX_W-1:0]       clr_q, clr_d;
  logic                    cand_q, cand_d;
  logic [VTX_W-1:0]        cand_v_q, cand_v_d;
  logic                    fwd_q, fwd_d;
  logic [VTX_W-1:0]        fwd_v_q, fwd_v_d;

  logic                    q_we;
  logic [VIDX_W-1:0]       q_waddr;
  logic [VTX_W-1:0]        q_wdata;
  logic [VTX_W-1:0]        q_rdata;

  logic                    v_we;
  logic [VIDX_W-1:0]       v_waddr;
  logic                    v_wdata;
  logic [VIDX_W-1:0]       v_raddr;
  logic                    v_rdata;
  logic                    cand_seen;

  logic [VTX_W-1:0]        e_first;
  logic [VTX_W-1:0]        e_second;
  logic                    e_hit;
  logic [VTX_W-1:0]        e_other;

  // pending vertex queue
  bfs_ram #(
    .WIDTH (VTX_W),
    .DEPTH (MAX_VERTICES)
  ) u_queue (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (q_waddr),
    .wdata_i (q_wdata),
    .raddr_i (head_q[VIDX_W-1:0]),
    .rdata_o (q_rdata)
  );

  // visited marks, cleared by a pass at the start of each traversal
  bfs_ram #(
    .WIDTH (1),
    .DEPTH (MAX_VERTICES)
  ) u_visited (
    .clk_i   (clk_i),
    .we_i    (v_we),
    .waddr_i (v_waddr),
    .wdata_i (v_wdata),
    .raddr_i (v_raddr),
    .rdata_o (v_rdata)
  );

  // neighbor match on the edge read back from the store
  assign e_first  = edge_rdata_i[EDGE_W-1:VTX_W];
  assign e_second = edge_rdata_i[VTX_W-1:0];

  always_comb begin
    e_hit   = 1'b1;
    e_other = e_second;
    if (e_first == u_q) begin
      e_other = e_second;
    end else if (e_second == u_q) begin
      e_other = e_first;
    end else begin
      e_hit = 1'b0;
    end
  end

  assign edge_raddr_o = iss_q[EIDX_W-1:0];

  // visited mark lookup of the neighbor, forwarding the mark written last cycle
  assign v_raddr   = e_other[VIDX_W-1:0];
  assign cand_seen = v_rdata || (fwd_q && (fwd_v_q == cand_v_q));

  // sequencer
  always_comb begin
    state_d  = state_q;
    head_d   = head_q;
    tail_d   = tail_q;
    iss_d    = iss_q;
    pv_d     = pv_q;
    u_d      = u_q;
    clr_d    = clr_q;
    cand_d   = 1'b0;
    cand_v_d = e_other;
    fwd_d    = 1'b0;
    fwd_v_d  = cand_v_q;
    q_we     = 1'b0;
    q_waddr  = tail_q[VIDX_W-1:0];
    q_wdata  = cand_v_q;
    v_we     = 1'b0;
    v_waddr  = cand_v_q[VIDX_W-1:0];
    v_wdata  = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        if (req_i.go) begin
          q_we    = 1'b1;
          q_waddr = '0;
          q_wdata = req_i.vertex;
          head_d  = '0;
          tail_d  = QCNT_W'(1);
          u_d     = req_i.vertex;
          clr_d   = '0;
          state_d = ST_CLR;
        end
      end
      ST_CLR: begin
        // clear every mark, the start vertex gets its mark in the same pass
        v_we    = 1'b1;
        v_waddr = clr_q;
        v_wdata = (clr_q == u_q[VIDX_W-1:0]);
        clr_d   = clr_q + VIDX_W'(1);
        if (clr_q == CLR_LAST) begin
          state_d = ST_DEQ;
        end
      end
      ST_DEQ: begin
        head_d  = head_q + QCNT_W'(1);
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        u_d     = q_rdata;
        iss_d   = '0;
        pv_d    = 1'b0;
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        // issue the next edge read
        if (iss_q < edge_count_i) begin
          iss_d = iss_q + ECNT_W'(1);
          pv_d  = 1'b1;
        end else begin
          pv_d  = 1'b0;
        end
        // neighbor of the edge that came back, its mark is read now
        cand_d = pv_q && e_hit && ({1'b0, e_other} < VTX_LIMIT);
        // mark and enqueue a neighbor that was not visited
        if (cand_q && !cand_seen) begin
          v_we   = 1'b1;
          q_we   = 1'b1;
          tail_d = tail_q + QCNT_W'(1);
          fwd_d  = 1'b1;
        end
        if (!(iss_q < edge_count_i) && !pv_q) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_ready_i) begin
          state_d = (head_q == tail_q) ? ST_IDLE : ST_DEQ;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      pv_q    <= 1'b0;
      cand_q  <= 1'b0;
      fwd_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      pv_q    <= pv_d;
      cand_q  <= cand_d;
      fwd_q   <= fwd_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    iss_q    <= iss_d;
    u_q      <= u_d;
    clr_q    <= clr_d;
    cand_v_q <= cand_v_d;
    fwd_v_q  <= fwd_v_d;
  end

  assign emit_o.valid  = (state_q == ST_EMIT);
  assign emit_o.vertex = u_q;
  assign emit_o.last   = (head_q == tail_q);
  assign busy_o        = (state_q != ST_IDLE);

  // queue pointers stay ordered and bounded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= tail_q)
    else $error("queue head passed tail");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_q <= QCNT_W'(MAX_VERTICES))
    else $error("queue tail beyond vertex count");

  // every vertex is enqueued at most once, so an enqueue always finds room
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && q_we) |-> (tail_q < QCNT_W'(MAX_VERTICES)))
    else $error("enqueue with a full vertex queue");

  // a vertex is handed out only after it was dequeued
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (head_q != '0))
    else $error("emit without a dequeued vertex");

endmodule

[rtl/bfs_graph_traversal_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfs_graph_traversal_unit
// Edge store with command decode and breadth-first traversal of the graph.
// ----------------------------------------------------------------------------
// Add-edge and clear transactions can follow back to back. A traverse
// transaction holds in_stall_o high while it runs: it first clears the
// visited marks in a pass over all MAX_VERTICES (64) marks, then every
// dequeued vertex goes through a queue read, a vertex load, one read of the
// single edge store port per stored edge, the edge read latency, the visited
// mark read latency, and the hand-off of the vertex to the output register,
// which waits while the output side stalls. Results come out in breadth-first
// order with last set on the final vertex; edges_dropped reports an add that
// found the store full since the last clear.
module bfs_graph_traversal_unit import bfs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  logic              busy;
  logic              in_fire;
  logic              a_ok;
  logic              b_ok;

  logic [ECNT_W-1:0] count_q, count_d;
  logic              ovf_q, ovf_d;
  logic              e_we;
  walk_req_t         req;

  logic [EIDX_W-1:0] e_raddr;
  logic [EDGE_W-1:0] e_rdata;

  emit_t             emit;
  logic              emit_ready;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_data_q;

  assign in_stall_o = busy;
  assign in_fire    = in_valid_i && !busy;
  assign a_ok       = ({1'b0, in_data_i.vertex_a} < VTX_LIMIT);
  assign b_ok       = ({1'b0, in_data_i.vertex_b} < VTX_LIMIT);

  // command decode
  always_comb begin
    count_d    = count_q;
    ovf_d      = ovf_q;
    e_we       = 1'b0;
    req.go     = 1'b0;
    req.vertex = in_data_i.vertex_a;
    if (in_fire) begin
      unique case (in_data_i.cmd)
        CMD_ADD: begin
          if (a_ok && b_ok) begin
            if (count_q == EDGE_FULL) begin
              ovf_d = 1'b1;
            end else begin
              e_we    = 1'b1;
              count_d = count_q + ECNT_W'(1);
            end
          end
        end
        CMD_TRAVERSE: begin
          req.go = a_ok;
        end
        CMD_CLEAR: begin
          count_d = '0;
          ovf_d   = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // edge store
  bfs_ram #(
    .WIDTH (EDGE_W),
    .DEPTH (MAX_EDGES)
  ) u_edges (
    .clk_i   (clk_i),
    .we_i    (e_we),
    .waddr_i (count_q[EIDX_W-1:0]),
    .wdata_i ({in_data_i.vertex_a, in_data_i.vertex_b}),
    .raddr_i (e_raddr),
    .rdata_o (e_rdata)
  );

  // traversal engine
  bfs_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req),
    .edge_count_i (count_q),
    .edge_raddr_o (e_raddr),
    .edge_rdata_i (e_rdata),
    .emit_o       (emit),
    .emit_ready_i (emit_ready),
    .busy_o       (busy)
  );

  // output register
  assign emit_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit.valid && emit_ready) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit.valid && emit_ready) begin
      out_data_q.vertex        <= emit.vertex;
      out_data_q.last          <= emit.last;
      out_data_q.edges_dropped <= ovf_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // edge count stays within the store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= EDGE_FULL)
    else $error("edge count beyond store depth");

  // overflow is only possible with a full store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (count_q == EDGE_FULL))
    else $error("overflow flag set with free edge slots");

endmodule

[dv/bfs_graph_traversal_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfs_graph_traversal_unit_test
// Self-checking bench for the breadth-first traversal unit. A scoreboard
// tracks the edge store and works out each traversal's visit order in
// breadth-first order. Output transactions are compared field by field. The
// stimulus is a directed part, a full store phase and then random graph
// episodes. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module bfs_graph_traversal_unit_test import bfs_pkg::*; ();

  // command code that the block ignores
  localparam cmd_e CMD_UNUSED = cmd_e'(2'd3);

  // cycles to wait after the last expected visit before ending
  localparam int TAIL_CYCLES = 600;
  // length of the long receiver hold-off
  localparam int HOLD_CYCLES = 500;
  // random transactions that do something
  localparam int RANDOM_ITEMS = 70;

  // edge store copy and expected visit order
  class visit_order_board;
    logic [VTX_W-1:0] first_end[MAX_EDGES];
    logic [VTX_W-1:0] second_end[MAX_EDGES];
    int               stored_edges;
    bit               dropped_flag;
    out_item_t        expected_visits[$];
    int               mismatch_count;

    function new();
      stored_edges   = 0;
      dropped_flag   = 1'b0;
      mismatch_count = 0;
    endfunction

    // update the store, or queue up the visit order of a traversal
    function void note_command(in_item_t item);
      bit               seen[MAX_VERTICES];
      logic [VTX_W-1:0] order[MAX_VERTICES];
      int               head;
      int               tail;
      logic [VTX_W-1:0] u;
      logic [VTX_W-1:0] other;
      bit               hit;
      out_item_t        visit;
      case (item.cmd)
        CMD_ADD: begin
          if (stored_edges >= MAX_EDGES) begin
            dropped_flag = 1'b1;
          end else begin
            first_end[stored_edges]  = item.vertex_a;
            second_end[stored_edges] = item.vertex_b;
            stored_edges++;
          end
        end
        CMD_TRAVERSE: begin
          foreach (seen[v]) seen[v] = 1'b0;
          head = 0;
          tail = 0;
          seen[item.vertex_a] = 1'b1;
          order[tail] = item.vertex_a;
          tail++;
          while (head < tail) begin
            u = order[head];
            head++;
            // neighbours in insertion order of the edges
            for (int i = 0; i < stored_edges; i++) begin
              hit = 1'b1;
              if (first_end[i] == u) begin
                other = second_end[i];
              end else if (second_end[i] == u) begin
                other = first_end[i];
              end else begin
                hit = 1'b0;
              end
              if (hit && !seen[other]) begin
                seen[other] = 1'b1;
                if (tail < MAX_VERTICES) begin
                  order[tail] = other;
                  tail++;
                end
              end
            end
            visit.vertex        = u;
            visit.last          = (head == tail);
            visit.edges_dropped = dropped_flag;
            expected_visits = {expected_visits, visit};
          end
        end
        CMD_CLEAR: begin
          stored_edges = 0;
          dropped_flag = 1'b0;
        end
        default: ;
      endcase
    endfunction

    // compare one output transaction with the oldest expected visit
    function void check_visit(out_item_t got);
      out_item_t want;
      if (expected_visits.size() == 0) begin
        $display("%0t: unexpected visit: expected none, actual vertex=%0d last=%0d dropped=%0d",
                 $time, got.vertex, got.last, got.edges_dropped);
        mismatch_count++;
        return;
      end
      want = expected_visits.pop_front();
      if (got.vertex !== want.vertex) begin
        $display("%0t: vertex mismatch: expected %0d, actual %0d",
                 $time, want.vertex, got.vertex);
        mismatch_count++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last mismatch at vertex %0d: expected %0d, actual %0d",
                 $time, want.vertex, want.last, got.last);
        mismatch_count++;
      end
      if (got.edges_dropped !== want.edges_dropped) begin
        $display("%0t: edges_dropped mismatch at vertex %0d: expected %0d, actual %0d",
                 $time, want.vertex, want.edges_dropped, got.edges_dropped);
        mismatch_count++;
      end
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;

  visit_order_board board;
  int burst_left;
  int active_items;
  int hold_asks;

  bfs_graph_traversal_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic in_item_t make_item(cmd_e c, int a, int b);
    in_item_t item;
    item.cmd      = c;
    item.vertex_a = a[VTX_W-1:0];
    item.vertex_b = b[VTX_W-1:0];
    return item;
  endfunction

  // any command with any vertices
  function automatic in_item_t noise_item();
    return make_item(cmd_e'($urandom_range(0, 3)), $urandom_range(0, 63),
                     $urandom_range(0, 63));
  endfunction

  // offer one transaction in bursts with random gaps, note it when taken
  task automatic send_item(in_item_t item);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_command(item);
    burst_left--;
    if (item.cmd != CMD_UNUSED) active_items++;
  endtask

  // stop offering until every expected visit is out
  task automatic drain_visits();
    in_valid_i <= 1'b0;
    while (board.expected_visits.size() != 0) @(posedge clk_i);
  endtask

  // one random graph: optional clear, edges on a vertex pool, traversals
  task automatic run_episode();
    int pool;
    int base;
    int n_adds;
    int n_walks;
    pool = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 64) : $urandom_range(2, 12);
    base = $urandom_range(0, MAX_VERTICES - pool);
    if ($urandom_range(0, 4) != 0) begin
      send_item(make_item(CMD_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63)));
    end
    n_adds = $urandom_range(0, 30);
    repeat (n_adds) begin
      if ($urandom_range(0, 19) == 0) send_item(noise_item());
      send_item(make_item(CMD_ADD, base + $urandom_range(0, pool - 1),
                          base + $urandom_range(0, pool - 1)));
    end
    n_walks = $urandom_range(1, 3);
    repeat (n_walks) begin
      send_item(make_item(CMD_TRAVERSE, base + $urandom_range(0, pool - 1),
                          $urandom_range(0, 63)));
    end
  endtask

  // receiver: check taken results, stall on its own pattern
  initial begin
    int mode_left;
    int stall_pct;
    int hold_left;
    int hold_served;
    mode_left   = 0;
    stall_pct   = 0;
    hold_left   = 0;
    hold_served = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) board.check_visit(out_data_o);
      if (hold_served != hold_asks) begin
        hold_served = hold_asks;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode_left = $urandom_range(10, 200);
          case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 25;
            2: stall_pct = 50;
            default: stall_pct = 85;
          endcase
        end
        mode_left--;
        out_stall_i <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // main sequence
  initial begin
    int random_start;
    int episode;
    board        = new();
    burst_left   = 0;
    active_items = 0;
    hold_asks    = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: isolated starts, field extremes, self loops, unused command
    send_item(make_item(CMD_TRAVERSE, 0, 63));
    send_item(make_item(CMD_TRAVERSE, 63, 0));
    send_item(make_item(CMD_ADD, 0, 63));
    send_item(make_item(CMD_ADD, 63, 63));
    send_item(make_item(CMD_ADD, 63, 1));
    send_item(make_item(CMD_ADD, 1, 2));
    send_item(make_item(CMD_ADD, 42, 21));
    send_item(make_item(CMD_UNUSED, 63, 0));
    send_item(make_item(CMD_TRAVERSE, 0, 0));
    send_item(make_item(CMD_TRAVERSE, 2, 63));
    send_item(make_item(CMD_TRAVERSE, 21, 42));
    send_item(make_item(CMD_CLEAR, 63, 63));
    send_item(make_item(CMD_TRAVERSE, 0, 21));
    send_item(make_item(CMD_ADD, 5, 5));
    send_item(make_item(CMD_TRAVERSE, 5, 0));
    send_item(make_item(CMD_UNUSED, 0, 63));
    send_item(make_item(CMD_TRAVERSE, 63, 42));
    drain_visits();

    // full store: extra adds are dropped and raise the sticky flag
    send_item(make_item(CMD_CLEAR, 0, 0));
    repeat (MAX_EDGES + 4) begin
      send_item(make_item(CMD_ADD, $urandom_range(0, 63), $urandom_range(0, 63)));
    end
    send_item(make_item(CMD_TRAVERSE, $urandom_range(0, 63), 0));
    send_item(make_item(CMD_TRAVERSE, 0, 63));
    send_item(make_item(CMD_CLEAR, 0, 0));
    send_item(make_item(CMD_TRAVERSE, 5, 0));
    drain_visits();

    // random graph episodes
    random_start = active_items;
    episode      = 0;
    while (active_items < random_start + RANDOM_ITEMS) begin
      // long receiver hold-off while traversals keep coming
      if (episode == 1) begin
        hold_asks++;
        repeat (3) send_item(make_item(CMD_TRAVERSE, $urandom_range(0, 63), 0));
      end
      run_episode();
      if ($urandom_range(0, 5) == 0) drain_visits();
      episode++;
    end

    drain_visits();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (board.mismatch_count == 0 && board.expected_visits.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
